@@ src/kpr_pkg.sv @@
`default_nettype none

package kpr_pkg;

    localparam int unsigned BtnWidth   = 12;
    localparam int unsigned CoordWidth = 8;
    localparam int unsigned CountWidth = 8;

    localparam logic [BtnWidth-1:0] BTN_A     = 12'h001;
    localparam logic [BtnWidth-1:0] BTN_START = 12'h008;
    localparam logic [BtnWidth-1:0] BTN_R     = 12'h100;
    localparam logic [BtnWidth-1:0] BTN_L     = 12'h200;
    localparam logic [BtnWidth-1:0] BTN_X     = 12'h400;
    localparam logic [BtnWidth-1:0] BTN_Y     = 12'h800;

    localparam logic [CountWidth-1:0] RepeatRateReset  = 8'd4;
    localparam logic [CountWidth-1:0] RepeatDelayReset = 8'd8;

    typedef enum logic [1:0] {
        REMAP_NONE    = 2'd0,
        REMAP_START_X = 2'd1,
        REMAP_SWAP_XY = 2'd2,
        REMAP_L_TO_A  = 2'd3
    } t_remap;

    typedef enum logic [1:0] {
        CFG_REMAP_MODE   = 2'd0,
        CFG_REPEAT_RATE  = 2'd1,
        CFG_REPEAT_DELAY = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        TOUCH_VALID     = 2'd0,
        TOUCH_X_INVALID = 2'd1,
        TOUCH_Y_INVALID = 2'd2,
        TOUCH_INVALID   = 2'd3
    } t_validity;

    // Applies one remap mode to a button set.
    function automatic logic [BtnWidth-1:0] remap(input t_remap mode,
                                                  input logic [BtnWidth-1:0] v);
        logic [BtnWidth-1:0] r;
        r = v;
        case (mode)
            REMAP_START_X: begin
                if ((v & BTN_START) != '0) r = v | BTN_X;
            end
            REMAP_SWAP_XY: begin
                r = v & ~(BTN_X | BTN_Y);
                if ((v & BTN_X) != '0) r = r | BTN_Y;
                if ((v & BTN_Y) != '0) r = r | BTN_X;
            end
            REMAP_L_TO_A: begin
                if ((v & BTN_L) != '0) r = v | BTN_A;
                r = r & ~(BTN_L | BTN_R);
            end
            default: begin
                r = v;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/keypad_repeat_and_touch_tracker.sv @@
`default_nettype none

// Keypad auto-repeat and touch tracker.
// Input channel (i_in_valid / o_in_ready): one beat is one frame sample with the
// lid state, the raw 12-bit button mask and one calibrated touch sample.
// Output channel (o_out_valid / i_out_ready): one beat per input beat, carrying
// the newly pressed, held and auto-repeat button sets after remapping, the last
// accepted touch position, the filtered touch contact and its press edge.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; index 0 is
// the remap mode, 1 the repeat rate, 2 the repeat delay. A rate or delay of zero
// is stored as one. Other indexes are ignored. Write only while idle.
// A beat is captured in the input register; the frame state update and the
// remapping then run through short logic into the output register. Throughput
// is one beat per cycle while the receiver takes each beat; the input register
// accepts a beat while it is empty, even if the output holds an untaken beat.
// When the receiver stalls, the output beat holds, the input register fills,
// and then o_in_ready drops until the output is taken.
// Reset clears the frame state (previous buttons, repeat counter, last position,
// previous touch), empties both registers and loads the register defaults:
// remap none, rate 4, delay 8. A closed lid blanks every output field and clears
// the touch contact but keeps the button history and the last position.
module keypad_repeat_and_touch_tracker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_lid_closed,
    input  wire logic [kpr_pkg::BtnWidth-1:0]       i_button_bits,
    input  wire logic [kpr_pkg::CoordWidth-1:0]     i_touch_x,
    input  wire logic [kpr_pkg::CoordWidth-1:0]     i_touch_y,
    input  wire logic [1:0]                         i_touch_validity,
    input  wire logic                               i_touch_down,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [kpr_pkg::BtnWidth-1:0]            o_pressed_bits,
    output logic [kpr_pkg::BtnWidth-1:0]            o_held_bits,
    output logic [kpr_pkg::BtnWidth-1:0]            o_repeat_bits,
    output logic [kpr_pkg::CoordWidth-1:0]          o_pos_x,
    output logic [kpr_pkg::CoordWidth-1:0]          o_pos_y,
    output logic                                    o_touch_held,
    output logic                                    o_touch_pressed,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [kpr_pkg::CountWidth-1:0]     i_cfg_data
);

    // Configuration registers.
    kpr_pkg::t_remap                  r_remap_mode;
    logic [kpr_pkg::CountWidth-1:0]   r_repeat_rate;
    logic [kpr_pkg::CountWidth-1:0]   r_repeat_delay;
    logic [kpr_pkg::CountWidth-1:0]   w_cfg_nonzero;

    // Input register.
    logic                             r_in_valid;
    logic                             r_in_lid;
    logic [kpr_pkg::BtnWidth-1:0]     r_in_btn;
    logic [kpr_pkg::CoordWidth-1:0]   r_in_x;
    logic [kpr_pkg::CoordWidth-1:0]   r_in_y;
    kpr_pkg::t_validity               r_in_validity;
    logic                             r_in_touch;

    // Frame state.
    logic [kpr_pkg::BtnWidth-1:0]     r_prev_btn,   n_prev_btn;
    logic [kpr_pkg::CountWidth-1:0]   r_count,      n_count;
    logic [kpr_pkg::CoordWidth-1:0]   r_last_x,     n_last_x;
    logic [kpr_pkg::CoordWidth-1:0]   r_last_y,     n_last_y;
    logic                             r_prev_touch, n_prev_touch;

    // Output register.
    logic                             r_out_valid;
    logic [kpr_pkg::BtnWidth-1:0]     n_pressed, n_held, n_repeat;
    logic [kpr_pkg::CoordWidth-1:0]   n_pos_x, n_pos_y;
    logic                             n_touch_held, n_touch_pressed;

    logic                             w_adv;
    logic                             w_in_take;
    logic [kpr_pkg::BtnWidth-1:0]     w_pressed_raw;
    logic [kpr_pkg::BtnWidth-1:0]     w_repeat_raw;
    logic [kpr_pkg::CountWidth-1:0]   w_count_dec;
    logic                             w_touch;

    // The input register moves into the output register whenever the output
    // register is empty or being emptied in the same cycle.
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    assign w_cfg_nonzero = (i_cfg_data == '0) ? kpr_pkg::CountWidth'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remap_mode   <= kpr_pkg::REMAP_NONE;
            r_repeat_rate  <= kpr_pkg::RepeatRateReset;
            r_repeat_delay <= kpr_pkg::RepeatDelayReset;
        end else if (i_cfg_valid) begin
            case (kpr_pkg::t_cfg_reg'(i_cfg_index))
                kpr_pkg::CFG_REMAP_MODE:   r_remap_mode   <= kpr_pkg::t_remap'(i_cfg_data[1:0]);
                kpr_pkg::CFG_REPEAT_RATE:  r_repeat_rate  <= w_cfg_nonzero;
                kpr_pkg::CFG_REPEAT_DELAY: r_repeat_delay <= w_cfg_nonzero;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_lid      <= i_lid_closed;
            r_in_btn      <= i_button_bits;
            r_in_x        <= i_touch_x;
            r_in_y        <= i_touch_y;
            r_in_validity <= kpr_pkg::t_validity'(i_touch_validity);
            r_in_touch    <= i_touch_down;
        end
    end

    // Frame update for the sample sitting in the input register.
    always_comb begin
        n_prev_btn      = r_prev_btn;
        n_count         = r_count;
        n_last_x        = r_last_x;
        n_last_y        = r_last_y;
        n_prev_touch    = r_prev_touch;
        w_pressed_raw   = r_in_btn & ~r_prev_btn;
        w_repeat_raw    = w_pressed_raw;
        w_count_dec     = r_count - kpr_pkg::CountWidth'(1);
        w_touch         = r_in_touch;
        n_pressed       = '0;
        n_held          = '0;
        n_repeat        = '0;
        n_pos_x         = '0;
        n_pos_y         = '0;
        n_touch_held    = 1'b0;
        n_touch_pressed = 1'b0;

        if (r_in_lid) begin
            // A closed lid blanks everything and drops the contact.
            n_prev_touch = 1'b0;
        end else begin
            // The counter only runs while the same nonzero mask stays held.
            if (r_in_btn != '0 && r_in_btn == r_prev_btn) begin
                if (w_count_dec == '0) begin
                    w_repeat_raw = r_in_btn;
                    n_count      = r_repeat_rate;
                end else begin
                    n_count = w_count_dec;
                end
            end else begin
                n_count = r_repeat_delay;
            end
            n_prev_btn = r_in_btn;

            // An invalid axis is only tolerated while contact continues.
            if (r_in_validity == kpr_pkg::TOUCH_VALID) begin
                n_last_x = r_in_x;
                n_last_y = r_in_y;
            end else if (r_prev_touch) begin
                if (r_in_validity == kpr_pkg::TOUCH_X_INVALID) begin
                    n_last_y = r_in_y;
                end else if (r_in_validity == kpr_pkg::TOUCH_Y_INVALID) begin
                    n_last_x = r_in_x;
                end
            end else begin
                w_touch = 1'b0;
            end
            n_prev_touch = w_touch;

            n_pressed       = kpr_pkg::remap(r_remap_mode, w_pressed_raw);
            n_held          = kpr_pkg::remap(r_remap_mode, r_in_btn);
            n_repeat        = kpr_pkg::remap(r_remap_mode, w_repeat_raw);
            n_pos_x         = n_last_x;
            n_pos_y         = n_last_y;
            n_touch_held    = w_touch;
            n_touch_pressed = w_touch && !r_prev_touch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn   <= '0;
            r_count      <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_prev_touch <= 1'b0;
        end else if (w_adv) begin
            r_prev_btn   <= n_prev_btn;
            r_count      <= n_count;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_prev_touch <= n_prev_touch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_pressed_bits  <= n_pressed;
            o_held_bits     <= n_held;
            o_repeat_bits   <= n_repeat;
            o_pos_x         <= n_pos_x;
            o_pos_y         <= n_pos_y;
            o_touch_held    <= n_touch_held;
            o_touch_pressed <= n_touch_pressed;
        end
    end

    // A touch press edge always comes with contact.
    a_press_implies_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_touch_pressed |-> o_touch_held)
        else $error("touch press reported without contact");

    // Remapping keeps newly pressed buttons inside the held set.
    a_pressed_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressed_bits & ~o_held_bits) == '0)
        else $error("pressed button not in held set");

    // The repeat set always contains the newly pressed buttons.
    a_pressed_in_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressed_bits & ~o_repeat_bits) == '0)
        else $error("pressed button missing from repeat set");

    // Rate and delay must never hold zero, or the counter would wrap.
    a_timing_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_repeat_rate != '0 && r_repeat_delay != '0)
        else $error("repeat rate or delay is zero");

    // A sample leaving the input register always lands in the output register.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("output register lost a beat");

endmodule

`default_nettype wire
